[src/ir_pdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pdd_pkg
// Shared types and constants of the IR pulse-distance command dimmer.
// ----------------------------------------------------------------------------
package ir_pdd_pkg;

	// fixed field widths
	localparam int TICK_W  = 9;
	localparam int CODE_W  = 64;
	localparam int SLOT_W  = 16;
	localparam int LEVEL_W = 16;
	localparam int CMD_W   = 3;
	localparam int CNT_OUT_W = 6;
	localparam int NUM_CODES = 5;
	localparam int NUM_WORDS = 4;
	localparam int CFG_IDX_W = 3;

	// interval counter saturation
	localparam logic [TICK_W-1:0] TICK_MAX = 9'd511;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CODE_PRESET_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_PRESET_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_PRESET_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_STEP_UP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_STEP_DOWN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_MIN      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_MAX      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT    = 3'd7;

	// configuration reset values
	localparam logic [TICK_W-1:0] ONE_BIT_MIN_RST   = 9'd5;
	localparam logic [TICK_W-1:0] ONE_BIT_MAX_RST   = 9'd9;
	localparam logic [TICK_W-1:0] FRAME_TIMEOUT_RST = 9'd300;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PRESET_LOW  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PRESET_MID  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PRESET_HIGH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STEP_UP     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STEP_DOWN   = 3'd4;

	// lamp levels
	localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 16'd6550;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 16'd6550;
	localparam logic [LEVEL_W-1:0] LEVEL_MID    = 16'd26200;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 16'd45850;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 16'hFFFF;
	localparam logic [LEVEL_W-1:0] STEP_UP      = 16'd1310;
	localparam logic [LEVEL_W-1:0] STEP_DOWN    = 16'd2620;

	// finished frame handed from the receiver to the command stage
	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic [CNT_OUT_W-1:0] bit_count;
	} frame_t;

endpackage

[src/ir_pdd_rx.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pdd_rx
// Frame receiver: edge detection, interval counting and bit shifting. Reports
// a finished frame combinationally in the tick that ends it.
// ----------------------------------------------------------------------------
module ir_pdd_rx #(
	parameter int MAX_BITS   = 63,
	parameter int WORD_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic                         ir_level,
	input  logic [ir_pdd_pkg::TICK_W-1:0] one_bit_min,
	input  logic [ir_pdd_pkg::TICK_W-1:0] one_bit_max,
	input  logic [ir_pdd_pkg::TICK_W-1:0] frame_timeout,
	output logic                         done,
	output ir_pdd_pkg::frame_t           frame
);
	import ir_pdd_pkg::*;

	localparam int CNT_W = $clog2(MAX_BITS + 1);

	logic                  recv_q;
	logic                  prev_q;
	logic [TICK_W-1:0]     interval_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [WORD_WIDTH-1:0] words_q [NUM_WORDS];

	logic                  recv_n;
	logic [TICK_W-1:0]     interval_n;
	logic [CNT_W-1:0]      cnt_n;
	logic [WORD_WIDTH-1:0] words_n [NUM_WORDS];
	logic                  falling;
	logic                  bit_val;
	logic [TICK_W-1:0]     interval_inc;

	assign falling = prev_q & ~ir_level;

	// per-tick receiver update
	always_comb begin
		recv_n     = recv_q;
		interval_n = interval_q;
		cnt_n      = cnt_q;
		words_n    = words_q;
		done       = 1'b0;
		bit_val    = 1'b0;
		interval_inc = (interval_q < TICK_MAX) ? interval_q + 1'b1 : interval_q;
		if (!recv_q) begin
			if (falling) begin
				recv_n     = 1'b1;
				interval_n = '0;
				cnt_n      = '0;
				for (int k = 0; k < NUM_WORDS; k++) begin
					words_n[k] = '0;
				end
			end
		end else begin
			interval_n = interval_inc;
			if (falling) begin
				bit_val = (interval_inc > one_bit_min) && (interval_inc < one_bit_max);
				// word k takes bits k*WORD_WIDTH up to the next word boundary
				for (int k = 0; k < NUM_WORDS; k++) begin
					if (int'(cnt_q) >= k * WORD_WIDTH && int'(cnt_q) < (k + 1) * WORD_WIDTH) begin
						words_n[k] = {words_q[k][WORD_WIDTH-2:0], bit_val};
					end
				end
				cnt_n      = cnt_q + 1'b1;
				interval_n = '0;
				if (cnt_n >= CNT_W'(MAX_BITS)) begin
					done = 1'b1;
				end
			end
			if (interval_n >= frame_timeout) begin
				done = 1'b1;
			end
			if (done) begin
				recv_n = 1'b0;
			end
		end
	end

	// finished frame contents
	always_comb begin
		frame.code = '0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			frame.code[k*SLOT_W +: SLOT_W] = SLOT_W'(words_n[k]);
		end
		frame.bit_count = CNT_OUT_W'(cnt_n);
	end

	// receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q     <= 1'b0;
			prev_q     <= 1'b1;
			interval_q <= '0;
			cnt_q      <= '0;
			for (int k = 0; k < NUM_WORDS; k++) begin
				words_q[k] <= '0;
			end
		end else if (take) begin
			recv_q     <= recv_n;
			prev_q     <= ir_level;
			interval_q <= interval_n;
			cnt_q      <= cnt_n;
			words_q    <= words_n;
		end
	end

endmodule

[src/ir_pulse_distance_command_dimmer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_dimmer_core
// IR pulse-distance decoder with code matching and lamp level control.
// ----------------------------------------------------------------------------
// Takes one IR line sample per transaction and accepts a new sample every
// clock cycle while in_ready is high. The frame receiver updates in the
// cycle a sample is accepted; a finished frame is held in a stage register,
// then matched against the five configured codes and applied to the lamp
// level as it moves into an output register, where the result sits until
// taken. Input stalls only while both the stage and the output register
// hold results. Configuration writes are always ready and take effect at
// once; write them while no frame is in progress.
module ir_pulse_distance_command_dimmer_core #(
	parameter int MAX_BITS   = 63,
	parameter int WORD_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             ir_level,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             matched,
	output logic [ir_pdd_pkg::CMD_W-1:0]     command_index,
	output logic [ir_pdd_pkg::LEVEL_W-1:0]   drive_level,
	output logic [ir_pdd_pkg::CNT_OUT_W-1:0] bits_received,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ir_pdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ir_pdd_pkg::CODE_W-1:0]    cfg_data
);
	import ir_pdd_pkg::*;

	logic [CODE_W-1:0]  code_q [NUM_CODES];
	logic [TICK_W-1:0]  one_bit_min_q;
	logic [TICK_W-1:0]  one_bit_max_q;
	logic [TICK_W-1:0]  frame_timeout_q;
	logic [LEVEL_W-1:0] level_q;

	logic     in_fire;
	logic     rx_done;
	frame_t   rx_frame;
	logic     valid_s1;
	frame_t   frame_s1;
	logic     adv_s1;

	logic               hit;
	logic [CMD_W-1:0]   cmd;
	logic [LEVEL_W-1:0] level_n;
	logic [LEVEL_W:0]   level_sum;

	logic               out_valid_q;
	logic               matched_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [LEVEL_W-1:0] drive_q;
	logic [CNT_OUT_W-1:0] bits_q;

	// handshakes
	assign adv_s1    = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || adv_s1;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CODES; i++) begin
				code_q[i] <= '0;
			end
			one_bit_min_q   <= ONE_BIT_MIN_RST;
			one_bit_max_q   <= ONE_BIT_MAX_RST;
			frame_timeout_q <= FRAME_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CODE_PRESET_LOW:  code_q[0] <= cfg_data;
				REG_CODE_PRESET_MID:  code_q[1] <= cfg_data;
				REG_CODE_PRESET_HIGH: code_q[2] <= cfg_data;
				REG_CODE_STEP_UP:     code_q[3] <= cfg_data;
				REG_CODE_STEP_DOWN:   code_q[4] <= cfg_data;
				REG_ONE_BIT_MIN:      one_bit_min_q <= cfg_data[TICK_W-1:0];
				REG_ONE_BIT_MAX:      one_bit_max_q <= cfg_data[TICK_W-1:0];
				REG_FRAME_TIMEOUT:    frame_timeout_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// frame receiver
	ir_pdd_rx #(
		.MAX_BITS   (MAX_BITS),
		.WORD_WIDTH (WORD_WIDTH)
	) u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (in_fire),
		.ir_level      (ir_level),
		.one_bit_min   (one_bit_min_q),
		.one_bit_max   (one_bit_max_q),
		.frame_timeout (frame_timeout_q),
		.done          (rx_done),
		.frame         (rx_frame)
	);

	// finished frame stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= rx_done;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && rx_done) begin
			frame_s1 <= rx_frame;
		end
	end

	// code match, first entry wins
	always_comb begin
		hit = 1'b0;
		cmd = CMD_PRESET_LOW;
		for (int i = NUM_CODES - 1; i >= 0; i--) begin
			if (code_q[i] == frame_s1.code) begin
				hit = 1'b1;
				cmd = CMD_W'(i);
			end
		end
	end

	// level update
	always_comb begin
		level_sum = {1'b0, level_q} + {1'b0, STEP_UP};
		level_n   = level_q;
		if (hit) begin
			case (cmd)
				CMD_PRESET_LOW:  level_n = LEVEL_LOW;
				CMD_PRESET_MID:  level_n = LEVEL_MID;
				CMD_PRESET_HIGH: level_n = LEVEL_HIGH;
				CMD_STEP_UP:     level_n = level_sum[LEVEL_W] ? LEVEL_MAX : level_sum[LEVEL_W-1:0];
				CMD_STEP_DOWN:   level_n = (level_q < STEP_DOWN) ? '0 : level_q - STEP_DOWN;
				default:         level_n = level_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LEVEL_RESET;
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				level_q <= level_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			matched_q <= hit;
			cmd_q     <= cmd;
			drive_q   <= level_n;
			bits_q    <= frame_s1.bit_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign matched       = matched_q;
	assign command_index = cmd_q;
	assign drive_level   = drive_q;
	assign bits_received = bits_q;

endmodule

[src/ir_pdd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pdd_checker
// Port-level checks of the dimmer core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ir_pdd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        matched,
	input logic [2:0]  command_index,
	input logic [15:0] drive_level,
	input logic [5:0]  bits_received
);
	import ir_pdd_pkg::*;

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched)
			&& $stable(command_index) && $stable(drive_level) && $stable(bits_received))
		else $error("result changed while stalled");

	// input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// no match reports command zero
	a_nomatch_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> command_index == CMD_PRESET_LOW)
		else $error("command index set without match");

	// presets load their fixed levels
	a_preset_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |->
			(command_index == CMD_PRESET_LOW && drive_level == LEVEL_LOW)
			|| (command_index == CMD_PRESET_MID && drive_level == LEVEL_MID)
			|| (command_index == CMD_PRESET_HIGH && drive_level == LEVEL_HIGH)
			|| command_index == CMD_STEP_UP || command_index == CMD_STEP_DOWN)
		else $error("bad preset level or command index");

endmodule

bind ir_pulse_distance_command_dimmer_core ir_pdd_checker u_ir_pdd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.matched       (matched),
	.command_index (command_index),
	.drive_level   (drive_level),
	.bits_received (bits_received)
);
